// ===== src/deq_pkg.sv =====
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = ADDR_W + 1;
    localparam int CMD_W      = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FIRST = 3'd0,
        CMD_PUSH_LAST  = 3'd1,
        CMD_POP_FIRST  = 3'd2,
        CMD_POP_LAST   = 3'd3,
        CMD_PEEK_FIRST = 3'd4,
        CMD_PEEK_LAST  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } mem_req_t;

    // index sum below twice the depth folded back into the ring
    function automatic logic [ADDR_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = s;
        if (s >= SUM_W'(DEPTH))
        begin
            r = s - SUM_W'(DEPTH);
        end
        return r[ADDR_W-1:0];
    endfunction

endpackage

// ===== src/deq_if.sv =====
interface deq_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [deq_pkg::CMD_W-1:0]            cmd;
    logic signed [deq_pkg::VALUE_W-1:0]   push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink (input valid, input cmd, input push_value, output ready);
endinterface

interface deq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [deq_pkg::VALUE_W-1:0]   read_value;
    logic [deq_pkg::STATUS_W-1:0]         status;
    logic                                 empty_flag;
    logic                                 full_flag;

    modport source (output valid, output read_value, output status, output empty_flag,
                    output full_flag, input ready);
    modport sink (input valid, input read_value, input status, input empty_flag,
                  input full_flag, output ready);
endinterface

// ===== src/double_ended_queue_unit.sv =====
// double-ended queue of data words kept in a ring memory
// req channel: one beat per command (cmd, push_value); cmd 0/1 push at the
//   first/last end, 2/3 pop from the first/last end, 4/5 peek, 6/7 no-op
// rsp channel: exactly one beat per command with read_value, status
//   (0 ok, 1 empty error, 2 full error), empty_flag and full_flag
// a refused command leaves the queue unchanged; read_value is zero for
//   pushes, errors and no-ops
// timing: a push, an error or a no-op answers in the cycle after its beat;
//   a successful pop or peek passes the ring memory's registered read port
//   and the ST_READ state before it reaches the output register
// throughput: one command per cycle for pushes and errors while the response
//   drains; a successful pop or peek holds the command port during its read
// the response sits in an output register; while it is stalled a new
//   command is taken only if rsp.ready drains it in the same cycle
// reset clears the first-end index and the count, so the queue comes up
//   empty; ring entries hold no reset value and only live entries are read
module double_ended_queue_unit (
    input  logic      clk,
    input  logic      rst_n,
    deq_cmd_if.sink   req,
    deq_rsp_if.source rsp
);

    deq_pkg::mem_req_t                mem_req;
    logic [deq_pkg::DATA_WIDTH-1:0]   mem_rdata;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    deq_ram #(
        .DEPTH (deq_pkg::DEPTH),
        .WIDTH (deq_pkg::DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== src/deq_ram.sv =====
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/deq_ctrl.sv =====
module deq_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    deq_cmd_if.sink                          req,
    deq_rsp_if.source                        rsp,
    output deq_pkg::mem_req_t                mem_req,
    input  logic [deq_pkg::DATA_WIDTH-1:0]   mem_rdata
);

    deq_pkg::state_t                 state_reg, state_next;
    logic [deq_pkg::ADDR_W-1:0]      first_reg, first_next;
    logic [deq_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                            out_valid_reg, out_valid_next;
    logic [deq_pkg::VALUE_W-1:0]     read_value_reg, read_value_next;
    deq_pkg::status_t                status_reg, status_next;
    logic                            empty_reg, empty_next;
    logic                            full_reg, full_next;

    logic                            accept;
    logic                            is_empty;
    logic                            is_full;
    logic [deq_pkg::ADDR_W-1:0]      first_dec;
    logic [deq_pkg::ADDR_W-1:0]      first_inc;
    logic [deq_pkg::ADDR_W-1:0]      tail_pos;
    logic [deq_pkg::ADDR_W-1:0]      last_pos;
    logic [deq_pkg::DATA_WIDTH-1:0]  word;

    assign req.ready = (state_reg == deq_pkg::ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg >= deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign first_dec = (first_reg == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)
                                         : first_reg - deq_pkg::ADDR_W'(1);
    assign first_inc = (first_reg == deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)) ? '0
                                         : first_reg + deq_pkg::ADDR_W'(1);
    assign tail_pos  = deq_pkg::wrap_idx(deq_pkg::SUM_W'(first_reg)
                                         + deq_pkg::SUM_W'(count_reg));
    assign last_pos  = deq_pkg::wrap_idx(deq_pkg::SUM_W'(first_reg)
                                         + deq_pkg::SUM_W'(count_reg)
                                         - deq_pkg::SUM_W'(1));
    assign word      = deq_pkg::DATA_WIDTH'($unsigned(req.push_value));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::ST_IDLE;
            first_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
        empty_reg      <= empty_next;
        full_reg       <= full_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        empty_next      = empty_reg;
        full_next       = full_reg;
        mem_req         = '0;
        mem_req.wdata   = word;

        unique case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next  = 1'b1;
                    read_value_next = '0;
                    status_next     = deq_pkg::STAT_OK;
                    unique case (deq_pkg::cmd_t'(req.cmd))
                        deq_pkg::CMD_PUSH_FIRST:
                        begin
                            if (is_full)
                            begin
                                status_next = deq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                first_next    = first_dec;
                                count_next    = count_reg + deq_pkg::CNT_W'(1);
                                mem_req.we    = 1'b1;
                                mem_req.waddr = first_dec;
                            end
                        end
                        deq_pkg::CMD_PUSH_LAST:
                        begin
                            if (is_full)
                            begin
                                status_next = deq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                count_next    = count_reg + deq_pkg::CNT_W'(1);
                                mem_req.we    = 1'b1;
                                mem_req.waddr = tail_pos;
                            end
                        end
                        deq_pkg::CMD_POP_FIRST, deq_pkg::CMD_PEEK_FIRST:
                        begin
                            if (is_empty)
                            begin
                                status_next = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                state_next     = deq_pkg::ST_READ;
                                mem_req.re     = 1'b1;
                                mem_req.raddr  = first_reg;
                                if (deq_pkg::cmd_t'(req.cmd) == deq_pkg::CMD_POP_FIRST)
                                begin
                                    first_next = first_inc;
                                    count_next = count_reg - deq_pkg::CNT_W'(1);
                                end
                            end
                        end
                        deq_pkg::CMD_POP_LAST, deq_pkg::CMD_PEEK_LAST:
                        begin
                            if (is_empty)
                            begin
                                status_next = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                state_next     = deq_pkg::ST_READ;
                                mem_req.re     = 1'b1;
                                mem_req.raddr  = last_pos;
                                if (deq_pkg::cmd_t'(req.cmd) == deq_pkg::CMD_POP_LAST)
                                begin
                                    count_next = count_reg - deq_pkg::CNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            status_next = deq_pkg::STAT_OK;
                        end
                    endcase
                    empty_next = (count_next == '0);
                    full_next  = (count_next >= deq_pkg::CNT_W'(deq_pkg::DEPTH));
                end
            end
            deq_pkg::ST_READ:
            begin
                // pointer and count already hold the post-command values
                state_next      = deq_pkg::ST_IDLE;
                out_valid_next  = 1'b1;
                read_value_next = deq_pkg::VALUE_W'(mem_rdata);
                status_next     = deq_pkg::STAT_OK;
                empty_next      = is_empty;
                full_next       = is_full;
            end
            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.empty_flag = empty_reg;
    assign rsp.full_flag  = full_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
        else $error("entry count above depth");

    a_first_range: assert property (@(posedge clk) disable iff (!rst_n)
        first_reg <= deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1))
        else $error("first-end index outside ring");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == deq_pkg::ST_READ |-> !out_valid_reg)
        else $error("read pending while output register occupied");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_full && (req.cmd == deq_pkg::CMD_PUSH_FIRST
                               || req.cmd == deq_pkg::CMD_PUSH_LAST)
        |=> count_reg == $past(count_reg) + deq_pkg::CNT_W'(1))
        else $error("accepted push did not grow the deque");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(empty_reg && full_reg))
        else $error("empty and full flagged together");

endmodule
